// ===== hw/rtl/uerd_pkg.sv =====
// Shared types, constants and the seven-segment decode for the echo ranger.
// No dependencies; used by every uerd_* module and the top level.
`default_nettype none

package uerd_pkg;

  // config register widths and reset values
  localparam int unsigned SCALE_W    = 12;
  localparam int unsigned RANGE_W    = 10;
  localparam int unsigned TRIG_W     = 8;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [SCALE_W-1:0] SCALE_RST      = 12'd1098;
  localparam logic [RANGE_W-1:0] RANGE_LOW_RST  = 10'd5;
  localparam logic [RANGE_W-1:0] RANGE_HIGH_RST = 10'd200;
  localparam logic [TRIG_W-1:0]  TRIG_TICKS_RST = 8'd1;

  localparam int unsigned COUNT_BITS_DEF = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_TICKS = 2'd3;

  // a shown product is below 1023*1000, so 20 bits; shown value below 1023
  localparam int unsigned P_BITS   = 20;
  localparam int unsigned VAL_BITS = 10;
  localparam int unsigned SEG_W    = 8;
  localparam int unsigned POS_W    = 2;
  localparam logic [P_BITS-1:0] MILLI = 20'd1000;

  // floor(p/1000) estimate: (p*1048) >> 20, low by at most one
  localparam int unsigned RECIP_W     = 31;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 31'd1048;
  localparam int unsigned RECIP_SHIFT = 20;

  // x/10 = (x*205) >> 11, exact for x < 1029
  localparam int unsigned DIV10_W     = 18;
  localparam logic [DIV10_W-1:0] DIV10_MUL = 18'd205;
  localparam int unsigned DIV10_SHIFT = 11;

  localparam logic [POS_W-1:0] POS_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_TRIGGER = 2'd0,
    PH_RISE    = 2'd1,
    PH_FALL    = 2'd2
  } phase_t;

  // control that travels with each tick down the pipe
  typedef struct packed {
    logic trig;
    logic show;
  } item_ctl_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/uerd_fsm.sv =====
// Tick sequencer: trigger / rise / fall phases, tick counter and echo width.
// Depends on uerd_pkg. Output is a registered pipeline stage.
`default_nettype none

module uerd_fsm #(
  parameter int unsigned COUNT_BITS = uerd_pkg::COUNT_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_echo,
  input  wire  [uerd_pkg::TRIG_W-1:0]      trigger_ticks,
  output logic                             dn_valid,
  input  wire                              dn_ready,
  output uerd_pkg::item_ctl_t              dn_ctl,
  output logic [COUNT_BITS-1:0]            dn_width
);

  uerd_pkg::phase_t phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]       tick_r, tick_nxt;
  logic [COUNT_BITS-1:0]       rise_r, rise_nxt;
  logic [uerd_pkg::TRIG_W-1:0] tleft_r, tleft_nxt;
  logic [uerd_pkg::TRIG_W-1:0] tload;

  logic                  v_r, v_nxt;
  uerd_pkg::item_ctl_t   ctl_r, ctl_nxt;
  logic [COUNT_BITS-1:0] width_r, width_nxt;

  logic accept;

  assign in_ready = !v_r || dn_ready;
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    rise_nxt  = rise_r;
    tleft_nxt = tleft_r;
    tload     = '0;
    if (accept) begin
      tick_nxt = tick_r + COUNT_BITS'(1);
      case (phase_r)
        uerd_pkg::PH_RISE: begin
          if (in_echo) begin
            rise_nxt  = tick_r;
            phase_nxt = uerd_pkg::PH_FALL;
          end
        end
        uerd_pkg::PH_FALL: begin
          if (!in_echo) begin
            phase_nxt = uerd_pkg::PH_TRIGGER;
            tick_nxt  = '0;
            tleft_nxt = '0;
          end
        end
        default: begin
          // trigger phase; unused code behaves the same
          if (tleft_r == '0) begin
            tload = (trigger_ticks == '0) ? uerd_pkg::TRIG_W'(1) : trigger_ticks;
          end else begin
            tload = tleft_r;
          end
          tleft_nxt = tload - uerd_pkg::TRIG_W'(1);
          phase_nxt = (tleft_nxt == '0) ? uerd_pkg::PH_RISE : uerd_pkg::PH_TRIGGER;
        end
      endcase
    end
  end

  // item for the next stage
  always_comb begin
    ctl_nxt   = ctl_r;
    width_nxt = width_r;
    v_nxt     = dn_ready ? 1'b0 : v_r;
    if (accept) begin
      v_nxt        = 1'b1;
      ctl_nxt.trig = 1'b0;
      ctl_nxt.show = 1'b0;
      width_nxt    = tick_r - rise_r;
      case (phase_r)
        uerd_pkg::PH_RISE: ;
        uerd_pkg::PH_FALL: ctl_nxt.show = !in_echo && (tick_r > rise_r);
        default:           ctl_nxt.trig = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uerd_pkg::PH_TRIGGER;
      tick_r  <= '0;
      rise_r  <= '0;
      tleft_r <= '0;
      v_r     <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      rise_r  <= rise_nxt;
      tleft_r <= tleft_nxt;
      v_r     <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ctl_r   <= ctl_nxt;
    width_r <= width_nxt;
  end

  assign dn_valid = v_r;
  assign dn_ctl   = ctl_r;
  assign dn_width = width_r;

endmodule

`default_nettype wire

// ===== hw/rtl/uerd_scale.sv =====
// Two stages: width * scale with range window test, then quotient estimate of /1000.
// Depends on uerd_pkg.
`default_nettype none

module uerd_scale #(
  parameter int unsigned COUNT_BITS = uerd_pkg::COUNT_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               up_valid,
  output logic                              up_ready,
  input  uerd_pkg::item_ctl_t               up_ctl,
  input  wire  [COUNT_BITS-1:0]             up_width,
  input  wire  [uerd_pkg::SCALE_W-1:0]      scale_milli,
  input  wire  [uerd_pkg::RANGE_W-1:0]      range_low,
  input  wire  [uerd_pkg::RANGE_W-1:0]      range_high,
  output logic                              dn_valid,
  input  wire                               dn_ready,
  output uerd_pkg::item_ctl_t               dn_ctl,
  output logic [uerd_pkg::P_BITS-1:0]       dn_prod,
  output logic [uerd_pkg::VAL_BITS-1:0]     dn_qest
);

  localparam int unsigned PW = COUNT_BITS + uerd_pkg::SCALE_W;

  // stage a: product and window
  logic                          va_r;
  uerd_pkg::item_ctl_t           ctla_r;
  logic [uerd_pkg::P_BITS-1:0]   pa_r;
  logic                          rdy_a;
  logic [PW-1:0]                 prod;
  logic [uerd_pkg::P_BITS-1:0]   lo_k, hi_k;
  logic                          in_win;

  // stage b: quotient estimate
  logic                          vb_r;
  uerd_pkg::item_ctl_t           ctlb_r;
  logic [uerd_pkg::P_BITS-1:0]   pb_r;
  logic [uerd_pkg::VAL_BITS-1:0] qb_r;
  logic                          rdy_b;
  logic [uerd_pkg::RECIP_W-1:0]  qmul;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign up_ready = rdy_a;

  assign prod   = PW'(up_width) * PW'(scale_milli);
  assign lo_k   = uerd_pkg::P_BITS'(range_low) * uerd_pkg::MILLI;
  assign hi_k   = uerd_pkg::P_BITS'(range_high) * uerd_pkg::MILLI;
  assign in_win = (prod > PW'(lo_k)) && (prod < PW'(hi_k));

  assign qmul = uerd_pkg::RECIP_W'(pa_r) * uerd_pkg::RECIP_1000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= up_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && up_valid) begin
      ctla_r.trig <= up_ctl.trig;
      ctla_r.show <= up_ctl.show && in_win;
      pa_r        <= prod[uerd_pkg::P_BITS-1:0];
    end
    if (rdy_b && va_r) begin
      ctlb_r <= ctla_r;
      pb_r   <= pa_r;
      qb_r   <= qmul[uerd_pkg::RECIP_SHIFT +: uerd_pkg::VAL_BITS];
    end
  end

  assign dn_valid = vb_r;
  assign dn_ctl   = ctlb_r;
  assign dn_prod  = pb_r;
  assign dn_qest  = qb_r;

endmodule

`default_nettype wire

// ===== hw/rtl/uerd_digits.sv =====
// Result register: fixes the /1000 quotient, then sends one digit beat per cycle while
// out_ready is high, units first; a tick with no digits is one beat. Depends on uerd_pkg.
`default_nettype none

module uerd_digits (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              up_valid,
  output logic                             up_ready,
  input  uerd_pkg::item_ctl_t              up_ctl,
  input  wire  [uerd_pkg::P_BITS-1:0]      up_prod,
  input  wire  [uerd_pkg::VAL_BITS-1:0]    up_qest,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic                             out_trigger,
  output logic                             out_digit_valid,
  output logic [uerd_pkg::POS_W-1:0]       out_digit_position,
  output logic [uerd_pkg::SEG_W-1:0]       out_segments,
  output logic                             out_last
);

  logic                          v_r;
  uerd_pkg::item_ctl_t           ctl_r;
  logic [uerd_pkg::VAL_BITS-1:0] val_r, val_nxt;
  logic [uerd_pkg::POS_W-1:0]    pos_r;

  logic [uerd_pkg::P_BITS-1:0]   rem;
  logic [uerd_pkg::VAL_BITS-1:0] qfix;
  logic [uerd_pkg::DIV10_W-1:0]  dmul;
  logic [uerd_pkg::VAL_BITS-1:0] tenth;
  logic [uerd_pkg::VAL_BITS-1:0] digit_w;
  logic                          last_w, load, step;

  // estimate is low by at most one
  assign rem  = up_prod - uerd_pkg::P_BITS'(up_qest) * uerd_pkg::MILLI;
  assign qfix = (rem >= uerd_pkg::MILLI) ? up_qest + uerd_pkg::VAL_BITS'(1) : up_qest;

  assign dmul    = uerd_pkg::DIV10_W'(val_r) * uerd_pkg::DIV10_MUL;
  assign tenth   = uerd_pkg::VAL_BITS'(dmul[uerd_pkg::DIV10_W-1:uerd_pkg::DIV10_SHIFT]);
  assign digit_w = val_r - ((tenth << 3) + (tenth << 1));

  assign last_w   = !ctl_r.show || (pos_r == uerd_pkg::POS_LAST);
  assign up_ready = !v_r || (out_ready && last_w);
  assign load     = up_valid && up_ready;
  assign step     = v_r && out_ready && !last_w;
  assign val_nxt  = load ? qfix : tenth;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r <= up_ctl;
      val_r <= val_nxt;
      pos_r <= '0;
    end else if (step) begin
      val_r <= val_nxt;
      pos_r <= pos_r + uerd_pkg::POS_W'(1);
    end
  end

  assign out_valid          = v_r;
  assign out_trigger        = ctl_r.trig;
  assign out_digit_valid    = ctl_r.show;
  assign out_digit_position = ctl_r.show ? pos_r : '0;
  assign out_segments       = ctl_r.show ? uerd_pkg::seg_of(digit_w[3:0]) : '0;
  assign out_last           = last_w;

endmodule

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger_display.sv =====
// Top level of the ultrasonic echo ranger with seven-segment digit output.
// Depends on uerd_pkg, uerd_fsm, uerd_scale, uerd_digits.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | in_echo
//   out_    | output    | out_valid / out_ready | trigger, digit_valid, position, segments, last
//   cfg_    | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// A tick is taken every cycle while the output keeps up. Four register stages from
// in to out (sequencer, multiply, /1000 estimate, result register). The result
// register sends one beat a cycle while out_ready is high: a plain tick is one beat,
// a digit tick four beats, and it takes the next tick only with the last beat of the
// current one. out_ready low stalls every stage back to in_ready.
// Synchronous reset returns to the trigger phase with zeroed counters and reset config.
`default_nettype none

module ultrasonic_echo_ranger_display #(
  parameter int unsigned COUNT_BITS = uerd_pkg::COUNT_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  wire                                 in_echo,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic                                out_trigger,
  output logic                                out_digit_valid,
  output logic [uerd_pkg::POS_W-1:0]          out_digit_position,
  output logic [uerd_pkg::SEG_W-1:0]          out_segments,
  output logic                                out_last,
  input  wire                                 cfg_wr_en,
  input  wire  [uerd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [uerd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  logic [uerd_pkg::SCALE_W-1:0] scale_r;
  logic [uerd_pkg::RANGE_W-1:0] rlow_r;
  logic [uerd_pkg::RANGE_W-1:0] rhigh_r;
  logic [uerd_pkg::TRIG_W-1:0]  tticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= uerd_pkg::SCALE_RST;
      rlow_r   <= uerd_pkg::RANGE_LOW_RST;
      rhigh_r  <= uerd_pkg::RANGE_HIGH_RST;
      tticks_r <= uerd_pkg::TRIG_TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        uerd_pkg::REG_SCALE:      scale_r  <= cfg_wdata[uerd_pkg::SCALE_W-1:0];
        uerd_pkg::REG_RANGE_LOW:  rlow_r   <= cfg_wdata[uerd_pkg::RANGE_W-1:0];
        uerd_pkg::REG_RANGE_HIGH: rhigh_r  <= cfg_wdata[uerd_pkg::RANGE_W-1:0];
        uerd_pkg::REG_TRIG_TICKS: tticks_r <= cfg_wdata[uerd_pkg::TRIG_W-1:0];
        default: ;
      endcase
    end
  end

  logic                          s1_valid, s1_ready;
  uerd_pkg::item_ctl_t           s1_ctl;
  logic [COUNT_BITS-1:0]         s1_width;
  logic                          s3_valid, s3_ready;
  uerd_pkg::item_ctl_t           s3_ctl;
  logic [uerd_pkg::P_BITS-1:0]   s3_prod;
  logic [uerd_pkg::VAL_BITS-1:0] s3_qest;

  uerd_fsm #(
    .COUNT_BITS(COUNT_BITS)
  ) u_fsm (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_echo      (in_echo),
    .trigger_ticks(tticks_r),
    .dn_valid     (s1_valid),
    .dn_ready     (s1_ready),
    .dn_ctl       (s1_ctl),
    .dn_width     (s1_width)
  );

  uerd_scale #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (s1_valid),
    .up_ready   (s1_ready),
    .up_ctl     (s1_ctl),
    .up_width   (s1_width),
    .scale_milli(scale_r),
    .range_low  (rlow_r),
    .range_high (rhigh_r),
    .dn_valid   (s3_valid),
    .dn_ready   (s3_ready),
    .dn_ctl     (s3_ctl),
    .dn_prod    (s3_prod),
    .dn_qest    (s3_qest)
  );

  uerd_digits u_digits (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (s3_valid),
    .up_ready          (s3_ready),
    .up_ctl            (s3_ctl),
    .up_prod           (s3_prod),
    .up_qest           (s3_qest),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_trigger       (out_trigger),
    .out_digit_valid   (out_digit_valid),
    .out_digit_position(out_digit_position),
    .out_segments      (out_segments),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
